// ----- src/mrf_pkg.sv -----
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, constants and the CRC-16/MODBUS byte update for the request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

   localparam logic [7:0]  FUNC_WRITE          = 8'd6;
   localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd170;
   localparam logic [15:0] CRC_INIT            = 16'hFFFF;
   localparam logic [15:0] CRC_POLY            = 16'hA001;

   // frame byte positions: eight body bytes, then CRC low, then CRC high
   localparam int          BODY_LEN       = 8;
   localparam logic [3:0]  CRC_LOW_INDEX  = 4'd8;
   localparam logic [3:0]  CRC_HIGH_INDEX = 4'd9;

   typedef struct packed {
      logic [15:0] register_address;
      logic [31:0] register_value;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   // body bytes 0..7, byte 0 in the top bits
   typedef logic [8*BODY_LEN-1:0] body_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // reflected CRC update over one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'd0, data};
      for (int b = 0; b < 8; b++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

// ----- src/modbus_rtu_request_framer.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Builds a Modbus RTU write request frame with CRC-16/MODBUS per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one transaction per request (register address, 32-bit value),
//           taken at an edge with req_valid high and req_stall low.
//   rsp_* : ten transactions per request, one frame byte each in transmit
//           order: slave address, function 6, address (2 bytes, big-endian),
//           value (4 bytes, big-endian), CRC low, CRC high (last_byte set).
//   csr_* : slave address register, written when csr_write_enable is high;
//           change it only while no frame is pending.
// Timing: a taken request moves through the request stage and the queue into
//   the back end, which registers each byte at the output. Bytes follow one
//   per cycle while rsp_stall is low, frames back to back, with the CRC
//   updated one byte per cycle alongside. A request stage and a QUEUE_DEPTH
//   entry queue let new requests be taken while a frame is still being sent.
// Reset: clears all pending frames and sets the slave address to 170.
// Stall: rsp_stall holds the current byte; the back end freezes, and once
//   the queue and request stage fill, req_stall rises.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer import mrf_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   body_type         q_push_data;
   body_type         q_pop_data;

   mrf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   mrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   mrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop_data (q_pop_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- src/mrf_front.sv -----
// ----------------------------------------------------------------------------
// mrf_front
// Holds the slave address register, accepts requests and assembles the
// eight-byte frame body into a stage register ahead of the queue.
// ----------------------------------------------------------------------------
module mrf_front import mrf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             q_push,
   output body_type         q_push_data
);

   logic [7:0] slave_address_ff;
   logic       stage_valid_ff;
   logic       stage_valid_in;
   body_type   stage_body_ff;
   logic       req_take;

   assign q_push      = stage_valid_ff && !q_status.full;
   assign q_push_data = stage_body_ff;
   // the stage frees up when its content moves into the queue
   assign req_stall   = stage_valid_ff && q_status.full;
   assign req_take    = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDRESS_RESET;
         stage_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_write_enable) begin
            slave_address_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_body_ff <= {slave_address_ff, FUNC_WRITE,
                           req_data.register_address, req_data.register_value};
      end
   end

endmodule

// ----- src/mrf_queue.sv -----
// ----------------------------------------------------------------------------
// mrf_queue
// Short register queue of frame bodies between the front and the back.
// ----------------------------------------------------------------------------
module mrf_queue import mrf_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  body_type         push_data,
   input  logic             pop,
   output body_type         pop_data,
   output queue_status_type status
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

   body_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;

   assign status.full  = (count_ff == COUNT_MAX);
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < COUNT_MAX))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ----- src/mrf_back.sv -----
// ----------------------------------------------------------------------------
// mrf_back
// Takes frame bodies from the queue and sends ten bytes per frame, one per
// cycle while not stalled, updating the CRC as each body byte leaves.
// ----------------------------------------------------------------------------
module mrf_back import mrf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  body_type         q_pop_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic        busy_ff;
   logic [3:0]  idx_ff;
   body_type    body_ff;
   logic [15:0] crc_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic        out_free;
   logic        finishing;
   logic        load;
   rsp_type     next_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finishing = busy_ff && out_free && (idx_ff == CRC_HIGH_INDEX);
   assign load      = (!busy_ff || finishing) && !q_status.empty;
   assign q_pop     = load;

   always_comb begin
      next_rsp.last_byte = (idx_ff == CRC_HIGH_INDEX);
      priority if (idx_ff < CRC_LOW_INDEX) begin
         next_rsp.frame_byte = body_ff[8*BODY_LEN-1 -: 8];
      end else if (idx_ff == CRC_LOW_INDEX) begin
         next_rsp.frame_byte = crc_ff[7:0];
      end else begin
         next_rsp.frame_byte = crc_ff[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= busy_ff;
         end
         if (load) begin
            busy_ff <= 1'b1;
         end else if (finishing) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && busy_ff) begin
         rsp_data_ff <= next_rsp;
      end
      if (load) begin
         idx_ff  <= '0;
         body_ff <= q_pop_data;
         crc_ff  <= CRC_INIT;
      end else if (out_free && busy_ff) begin
         // advance to the next byte; CRC covers body bytes only
         idx_ff  <= idx_ff + 1'b1;
         body_ff <= body_ff << 8;
         if (idx_ff < CRC_LOW_INDEX) begin
            crc_ff <= crc_byte(crc_ff, body_ff[8*BODY_LEN-1 -: 8]);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= CRC_HIGH_INDEX))
      else $error("byte index out of frame");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      finishing |=> (rsp_valid_ff && rsp_data_ff.last_byte))
      else $error("frame end not marked on final byte");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!busy_ff || (idx_ff == CRC_HIGH_INDEX)))
      else $error("new frame loaded while one is in progress");

endmodule
